FILE: rtl/gjd_pkg.sv
// Shared types, constants and table functions for the Gregorian / Julian day number converter.
package gjd_pkg;

	// Pipeline depths: both conversion cores take the same number of stages.
	localparam int CORE_STAGES = 6;
	localparam int FIN_STAGES  = 2;
	localparam int LATENCY     = CORE_STAGES + FIN_STAGES;

	// Conversion modes.
	localparam logic MODE_DATE_TO_JDN = 1'b0;
	localparam logic MODE_JDN_TO_DATE = 1'b1;

	// Valid input ranges.
	localparam logic [22:0] JDN_MIN   = 23'd1721426;
	localparam logic [22:0] JDN_MAX   = 23'd5373484;
	localparam logic [22:0] JDN_EPOCH = 23'd1721119;
	localparam logic [13:0] YEAR_MAX  = 14'd9999;
	localparam logic [3:0]  MONTH_MAX = 4'd12;

	// Calendar constants.
	localparam logic [14:0] YEAR_BIAS    = 15'd4800;
	localparam logic [23:0] JDN_BIAS     = 24'd32045;
	localparam logic [17:0] DAYS_QUAD    = 18'd146097;
	localparam logic [10:0] DAYS_4Y      = 11'd1461;
	localparam logic [8:0]  DAYS_YEAR    = 9'd365;

	// Reciprocals for constant division: q = (n * RCP) >> SH, exact over the used range.
	localparam logic [12:0] RCP_100      = 13'd5243;
	localparam int          RCP_100_SH   = 19;
	localparam logic [23:0] RCP_QUAD     = 24'd15051803;
	localparam int          RCP_QUAD_SH  = 41;
	localparam logic [17:0] RCP_4Y       = 18'd183735;
	localparam int          RCP_4Y_SH    = 28;

	typedef struct packed {
		logic        mode;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [22:0] day_number;
	} gjd_req_t;

	typedef struct packed {
		logic [22:0] out_day_number;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [2:0]  weekday;
		logic        is_weekend;
		logic        is_leap;
		logic [4:0]  month_length;
		logic        range_error;
	} gjd_rsp_t;

	// A converted date as it leaves either core; ok is low when the input was out of range.
	typedef struct packed {
		logic        ok;
		logic [22:0] jdn;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} gjd_date_t;

	// Days before the start of each month of a year that begins in March.
	function automatic logic [8:0] cum_days(input logic [3:0] idx);
		logic [8:0] v;
		case (idx)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd61;
			4'd3:    v = 9'd92;
			4'd4:    v = 9'd122;
			4'd5:    v = 9'd153;
			4'd6:    v = 9'd184;
			4'd7:    v = 9'd214;
			4'd8:    v = 9'd245;
			4'd9:    v = 9'd275;
			4'd10:   v = 9'd306;
			4'd11:   v = 9'd337;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// Month index (0 = March) of a 1-based day of a March-based year.
	function automatic logic [3:0] mar_index(input logic [8:0] doy);
		logic [3:0] cnt;
		cnt = 4'd0;
		for (int k = 1; k < 12; k++) begin
			if (doy > cum_days(4'(k)))
				cnt = cnt + 4'd1;
		end
		return cnt;
	endfunction

	// Length of a month; months outside 1..12 return a filler that is never reported.
	function automatic logic [4:0] days_of(input logic [3:0] month, input logic leap);
		logic [4:0] v;
		case (month)
			4'd2:    v = leap ? 5'd29 : 5'd28;
			4'd4:    v = 5'd30;
			4'd6:    v = 5'd30;
			4'd9:    v = 5'd30;
			4'd11:   v = 5'd30;
			default: v = 5'd31;
		endcase
		return v;
	endfunction

	// Sum of the octal digits; congruent to the value modulo 7.
	function automatic logic [5:0] octal_sum(input logic [23:0] v);
		logic [5:0] s;
		s = 6'd0;
		for (int i = 0; i < 8; i++)
			s = s + 6'(v[3*i +: 3]);
		return s;
	endfunction

	// Reduce an octal digit sum to a value 0..6.
	function automatic logic [2:0] mod7_fold(input logic [5:0] s);
		logic [3:0] f;
		logic [3:0] g;
		f = 4'(s[5:3]) + 4'(s[2:0]);
		g = 4'(f[3]) + 4'(f[2:0]);
		return (g == 4'd7) ? 3'd0 : g[2:0];
	endfunction

endpackage

FILE: rtl/gjd_d2j.sv
// Date to Julian day number core: three compute stages and three alignment stages.
module gjd_d2j (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  gjd_pkg::gjd_req_t    req,
	output logic                 out_vld,
	output gjd_pkg::gjd_date_t   res
);

	// Stage 1: shift the year to start in March and check the ranges.
	logic        early_c;
	logic        ok_c;
	logic [14:0] yy_c;
	logic [3:0]  mm_c;

	assign early_c = (req.month < 4'd3);
	assign ok_c    = (req.year != 14'd0) && (req.year <= gjd_pkg::YEAR_MAX) &&
	                 (req.month != 4'd0) && (req.month <= gjd_pkg::MONTH_MAX);
	assign yy_c    = 15'(req.year) + gjd_pkg::YEAR_BIAS - 15'(early_c);
	assign mm_c    = early_c ? (req.month + 4'd9) : (req.month - 4'd3);

	logic        vld_s1, ok_s1;
	logic [14:0] yy_s1;
	logic [3:0]  mm_s1, month_s1;
	logic [13:0] year_s1;
	logic [4:0]  day_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1    <= ok_c;
		yy_s1    <= yy_c;
		mm_s1    <= mm_c;
		year_s1  <= req.year;
		month_s1 <= req.month;
		day_s1   <= req.day;
	end

	// Stage 2: century count by reciprocal, the plain day count of whole years and the days before the month.
	logic [27:0] p100_c;
	logic [23:0] base_c;

	assign p100_c = 28'(yy_s1) * 28'(gjd_pkg::RCP_100);
	assign base_c = 24'(yy_s1) * 24'(gjd_pkg::DAYS_YEAR) + 24'(yy_s1[14:2]);

	logic        vld_s2, ok_s2;
	logic [8:0]  q100_s2, cum_s2;
	logic [23:0] base_s2;
	logic [3:0]  month_s2;
	logic [13:0] year_s2;
	logic [4:0]  day_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2    <= ok_s1;
		q100_s2  <= p100_c[gjd_pkg::RCP_100_SH +: 9];
		cum_s2   <= gjd_pkg::cum_days(mm_s1);
		base_s2  <= base_c;
		month_s2 <= month_s1;
		year_s2  <= year_s1;
		day_s2   <= day_s1;
	end

	// Stage 3: leap-day corrections and the final sum.
	logic [23:0] jdn_c;

	assign jdn_c = base_s2 + 24'(day_s2) + 24'(cum_s2) - 24'(q100_s2) +
	               24'(q100_s2[8:2]) - gjd_pkg::JDN_BIAS;

	logic                 vld_s3, vld_s4, vld_s5, vld_s6;
	gjd_pkg::gjd_date_t   res_s3, res_s4, res_s5, res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		res_s3.ok    <= ok_s2;
		res_s3.jdn   <= jdn_c[22:0];
		res_s3.year  <= year_s2;
		res_s3.month <= month_s2;
		res_s3.day   <= day_s2;
		res_s4       <= res_s3;
		res_s5       <= res_s4;
		res_s6       <= res_s5;
	end

	assign out_vld = vld_s6;
	assign res     = res_s6;

endmodule

FILE: rtl/gjd_j2d.sv
// Julian day number to date core: six stages, with constant divisions done by reciprocal multiplication.
module gjd_j2d (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  gjd_pkg::gjd_req_t    req,
	output logic                 out_vld,
	output gjd_pkg::gjd_date_t   res
);

	// Stage 1: range check and offset to the March-based epoch.
	logic        ok_c;
	logic [21:0] t_c;
	logic [23:0] n_c;

	assign ok_c = (req.day_number >= gjd_pkg::JDN_MIN) && (req.day_number <= gjd_pkg::JDN_MAX);
	assign t_c  = 22'(req.day_number - gjd_pkg::JDN_EPOCH);
	assign n_c  = {t_c, 2'b00} - 24'd1;

	logic        vld_s1, ok_s1;
	logic [23:0] n_s1;
	logic [22:0] jdn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		ok_s1  <= ok_c;
		n_s1   <= n_c;
		jdn_s1 <= req.day_number;
	end

	// Stage 2: number of whole centuries since the March-based epoch.
	logic [47:0] pq_c;

	assign pq_c = 48'(n_s1) * 48'(gjd_pkg::RCP_QUAD);

	logic        vld_s2, ok_s2;
	logic [23:0] n_s2;
	logic [6:0]  cent_s2;
	logic [22:0] jdn_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ok_s2   <= ok_s1;
		n_s2    <= n_s1;
		cent_s2 <= pq_c[gjd_pkg::RCP_QUAD_SH +: 7];
		jdn_s2  <= jdn_s1;
	end

	// Stage 3: remainder inside the century.
	logic [24:0] sub_c;
	logic [23:0] r_c;
	logic [17:0] m2_c;

	assign sub_c = 25'(cent_s2) * 25'(gjd_pkg::DAYS_QUAD);
	assign r_c   = n_s2 - sub_c[23:0];
	assign m2_c  = {r_c[17:2], 2'b11};

	logic        vld_s3, ok_s3;
	logic [17:0] m2_s3;
	logic [6:0]  cent_s3;
	logic [22:0] jdn_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3   <= ok_s2;
		m2_s3   <= m2_c;
		cent_s3 <= cent_s2;
		jdn_s3  <= jdn_s2;
	end

	// Stage 4: year within the century.
	logic [35:0] py_c;

	assign py_c = 36'(m2_s3) * 36'(gjd_pkg::RCP_4Y);

	logic        vld_s4, ok_s4;
	logic [17:0] m2_s4;
	logic [6:0]  cent_s4, yic_s4;
	logic [22:0] jdn_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4   <= ok_s3;
		m2_s4   <= m2_s3;
		cent_s4 <= cent_s3;
		yic_s4  <= py_c[gjd_pkg::RCP_4Y_SH +: 7];
		jdn_s4  <= jdn_s3;
	end

	// Stage 5: day of the March-based year and the March-based year number.
	logic [17:0] dd2w_c;
	logic [10:0] dd2_c;
	logic [8:0]  dd3_c;
	logic [13:0] yc_c;

	assign dd2w_c = m2_s4 - 18'(yic_s4) * 18'(gjd_pkg::DAYS_4Y);
	assign dd2_c  = dd2w_c[10:0];
	assign dd3_c  = dd2_c[10:2] + 9'd1;
	assign yc_c   = 14'(cent_s4) * 14'd100 + 14'(yic_s4);

	logic        vld_s5, ok_s5;
	logic [8:0]  dd3_s5;
	logic [13:0] yc_s5;
	logic [22:0] jdn_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ok_s5  <= ok_s4;
		dd3_s5 <= dd3_c;
		yc_s5  <= yc_c;
		jdn_s5 <= jdn_s4;
	end

	// Stage 6: month and day; January and February belong to the next calendar year.
	logic [3:0] idx_c;
	logic       late_c;
	logic [8:0] dom_c;

	assign idx_c  = gjd_pkg::mar_index(dd3_s5);
	assign late_c = (idx_c >= 4'd10);
	assign dom_c  = dd3_s5 - gjd_pkg::cum_days(idx_c);

	logic                 vld_s6;
	gjd_pkg::gjd_date_t   res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		res_s6.ok    <= ok_s5;
		res_s6.jdn   <= jdn_s5;
		res_s6.year  <= yc_s5 + 14'(late_c);
		res_s6.month <= late_c ? (idx_c - 4'd9) : (idx_c + 4'd3);
		res_s6.day   <= dom_c[4:0];
	end

	assign out_vld = vld_s6;
	assign res     = res_s6;

endmodule

FILE: rtl/gjd_fin.sv
// Result stage: leap year, month length, weekday and error flags, with the output register.
module gjd_fin (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  gjd_pkg::gjd_date_t   date,
	output logic                 out_vld,
	output gjd_pkg::gjd_rsp_t    rsp
);

	// Stage 1: century of the year by reciprocal, and digit sum for the weekday.
	logic [26:0] pq_c;

	assign pq_c = 27'(date.year) * 27'(gjd_pkg::RCP_100);

	logic                 vld_s1;
	gjd_pkg::gjd_date_t   date_s1;
	logic [7:0]           q_s1;
	logic [5:0]           wsum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		date_s1 <= date;
		q_s1    <= pq_c[gjd_pkg::RCP_100_SH +: 8];
		wsum_s1 <= gjd_pkg::octal_sum(24'(date.jdn) + 24'd1);
	end

	// Stage 2: flags and the final result.
	logic [13:0]         hund_c;
	logic                leap_c;
	logic [4:0]          len_c;
	logic [2:0]          wd_c;
	gjd_pkg::gjd_rsp_t   rsp_c;

	assign hund_c = 14'(q_s1) * 14'd100;
	assign leap_c = (date_s1.year[1:0] == 2'd0) &&
	                ((date_s1.year != hund_c) || (q_s1[1:0] == 2'd0));
	assign len_c  = gjd_pkg::days_of(date_s1.month, leap_c);
	assign wd_c   = gjd_pkg::mod7_fold(wsum_s1);

	always_comb begin
		rsp_c = '0;
		if (!date_s1.ok) begin
			rsp_c.range_error = 1'b1;
		end else begin
			rsp_c.out_day_number = date_s1.jdn;
			rsp_c.out_year       = date_s1.year;
			rsp_c.out_month      = date_s1.month;
			rsp_c.out_day        = date_s1.day;
			rsp_c.weekday        = wd_c;
			rsp_c.is_weekend     = (wd_c == 3'd0) || (wd_c == 3'd6);
			rsp_c.is_leap        = leap_c;
			rsp_c.month_length   = len_c;
			rsp_c.range_error    = (date_s1.day == 5'd0) || (date_s1.day > len_c);
		end
	end

	logic                vld_s2;
	gjd_pkg::gjd_rsp_t   rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rsp_s2 <= rsp_c;
	end

	assign out_vld = vld_s2;
	assign rsp     = rsp_s2;

endmodule

FILE: rtl/gregorian_julian_day_converter.sv
// Top level of the Gregorian date / Julian day number converter pipeline.
//
//   Channel   Ports                 Direction   Transfer
//   request   start, busy, req      in          start high and busy low at a rising edge
//   result    done, rsp             out         done high for one cycle, always taken
//
// A request transfer may happen in every cycle; busy is held low because no stage
// ever waits. Each result passes six stages in the conversion core that matches
// the mode, then two result stages. The date-to-number core needs three compute
// stages and is padded to six so both cores deliver in order. Reset clears only the
// valid bits; the design keeps no state between items, and results cannot be stalled
// by the receiver.
module gregorian_julian_day_converter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  gjd_pkg::gjd_req_t    req,
	output logic                 done,
	output gjd_pkg::gjd_rsp_t    rsp
);

	logic                 take;
	logic                 d2j_in_vld, j2d_in_vld;
	logic                 d2j_vld, j2d_vld;
	gjd_pkg::gjd_date_t   d2j_res, j2d_res;
	logic                 fin_vld;
	gjd_pkg::gjd_date_t   fin_date;

	// The pipeline always advances, so every start is taken.
	assign busy = 1'b0;
	assign take = start && !busy;

	// Each core only sees valid items of its own mode; the other runs idle.
	assign d2j_in_vld = take && (req.mode == gjd_pkg::MODE_DATE_TO_JDN);
	assign j2d_in_vld = take && (req.mode == gjd_pkg::MODE_JDN_TO_DATE);

	gjd_d2j u_d2j (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (d2j_in_vld),
		.req     (req),
		.out_vld (d2j_vld),
		.res     (d2j_res)
	);

	gjd_j2d u_j2d (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (j2d_in_vld),
		.req     (req),
		.out_vld (j2d_vld),
		.res     (j2d_res)
	);

	// Both cores have the same depth, so at most one of them delivers in a cycle.
	assign fin_vld  = d2j_vld || j2d_vld;
	assign fin_date = j2d_vld ? j2d_res : d2j_res;

	gjd_fin u_fin (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (fin_vld),
		.date    (fin_date),
		.out_vld (done),
		.rsp     (rsp)
	);

`ifndef SYNTHESIS
	// The two cores are matched in depth and never collide at the merge point.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(d2j_vld && j2d_vld))
		else $error("both conversion cores delivered in the same cycle");

	// Every accepted request comes out after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##(gjd_pkg::LATENCY) done)
		else $error("result missing at the expected pipeline depth");

	// A result without error names a real day of its month.
	a_day_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.range_error) |->
			(rsp.out_day != 5'd0) && (rsp.out_day <= rsp.month_length))
		else $error("error-free result carries a day outside its month");

	// The weekday is reduced fully modulo seven.
	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.weekday != 3'd7))
		else $error("weekday not reduced below seven");
`endif

endmodule
